// ===== rtl/core/htd_pkg.sv =====
// shared types, sizes and codes of the huffman tree decoder
package htd_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int SYMBOL_BITS = 9;
  localparam int NODE_AW     = $clog2(NODE_COUNT);

  localparam int IDX_W     = 10;
  localparam int SYM_IN_W  = 9;
  localparam int OUT_SYM_W = 8;
  localparam int MODE_W    = 2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register select is paddr bit 2: root_node at 0, end_symbol at 4
  localparam logic CFG_SEL_ROOT = 1'b0;
  localparam logic CFG_SEL_END  = 1'b1;

  localparam logic [SYM_IN_W-1:0] END_SYMBOL_RESET = SYM_IN_W'(256);

  typedef enum logic [MODE_W-1:0] {
    M_LOAD    = 2'd0,
    M_BIT     = 2'd1,
    M_RESTART = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CUR,
    S_CHILD
  } state_t;

  typedef struct packed {
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
    logic [IDX_W-1:0]       zero;
    logic [IDX_W-1:0]       one;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic load;           // write one node entry
    logic restart;        // walk back to root, clear end state
    logic rd_cur;         // fetch entry of the current node
    logic rd_child_fast;  // fetch child using cached current entry
    logic rd_child_slow;  // fetch child using entry just read
    logic step;           // child is internal: it becomes current
    logic emit;           // child is a leaf: deliver result, back to root
  } cmd_t;

  typedef struct packed {
    logic cache_valid;
    logic ended;
    logic leaf;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/htd_in_if.sv =====
// input channel of the huffman tree decoder
interface htd_in_if;
  import htd_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [IDX_W-1:0]    node_index;
  logic                node_is_leaf;
  logic [SYM_IN_W-1:0] node_symbol;
  logic [IDX_W-1:0]    node_zero_child;
  logic [IDX_W-1:0]    node_one_child;
  logic                code_bit;

  modport source (
    output valid, mode, node_index, node_is_leaf, node_symbol,
           node_zero_child, node_one_child, code_bit,
    input  ready
  );

  modport sink (
    input  valid, mode, node_index, node_is_leaf, node_symbol,
           node_zero_child, node_one_child, code_bit,
    output ready
  );

endinterface

// ===== rtl/core/htd_out_if.sv =====
// result channel of the huffman tree decoder
interface htd_out_if;
  import htd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_SYM_W-1:0] symbol;
  logic                 end_mark;

  modport source (
    output valid, symbol, end_mark,
    input  ready
  );

  modport sink (
    input  valid, symbol, end_mark,
    output ready
  );

endinterface

// ===== rtl/core/huffman_tree_decoder.sv =====
// top level of the huffman tree decoder: config registers, controller and datapath
//
// Bit-serial Huffman decoder walking a code tree kept in a 1024-entry node store
// (one ram, registered read). A load transaction (mode 0) writes one node; a restart
// transaction (mode 2) puts the walk at root_node and clears the end state; a bit
// transaction (mode 1) steps to the zero or one child and, when that child is a leaf,
// delivers one result transaction: the symbol's low 8 bits, or end_mark with symbol 0
// when the leaf holds end_symbol. After an end mark, bit transactions are dropped
// until a restart. Load, restart and ignored transactions finish in the idle state.
// A bit is one node-store read of the child plus the decide step while the current
// node's entry is cached; the first bit after reset, a restart, a load or an emitted
// symbol first fetches that entry from the same read port. A leaf waits in place
// while the result register is still full. Nodes must be loaded before the walk
// reaches them; the store has no reset. Config is an APB-style port with pready
// tied high: root_node at byte 0, end_symbol at byte 4 (paddr bit 2 selects, low bits
// ignored); the user must write them only while the block is idle (not enforced).
module huffman_tree_decoder
  import htd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  htd_in_if.sink            in_ch,
  htd_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [IDX_W-1:0]    root_node_r;
  logic [SYM_IN_W-1:0] end_symbol_r;
  logic                cfg_wr;

  cmd_t    cmd;
  status_t status;

  // apb write lands at the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_node_r  <= '0;
      end_symbol_r <= END_SYMBOL_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_SEL_ROOT: root_node_r  <= pwdata[IDX_W-1:0];
        CFG_SEL_END:  end_symbol_r <= pwdata[SYM_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero-extended
  always_comb begin
    case (paddr[2])
      CFG_SEL_ROOT: prdata = CFG_DW'(root_node_r);
      CFG_SEL_END:  prdata = CFG_DW'(end_symbol_r);
      default:      prdata = '0;
    endcase
  end

  // sequencer: one transaction in flight, ready only when idle
  htd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // node store, walk state and the result register
  htd_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .root_node          (root_node_r),
    .end_symbol         (end_symbol_r),
    .in_node_index      (in_ch.node_index),
    .in_node_is_leaf    (in_ch.node_is_leaf),
    .in_node_symbol     (in_ch.node_symbol),
    .in_node_zero_child (in_ch.node_zero_child),
    .in_node_one_child  (in_ch.node_one_child),
    .in_code_bit        (in_ch.code_bit),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_symbol         (out_ch.symbol),
    .out_end_mark       (out_ch.end_mark)
  );

endmodule

// ===== rtl/core/htd_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/htd_ctrl.sv =====
// controller state machine of the huffman tree decoder
module htd_ctrl
  import htd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  status_t           status,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            M_LOAD:    cmd.load = 1'b1;
            M_RESTART: cmd.restart = 1'b1;
            M_BIT: begin
              if (!status.ended) begin
                if (status.cache_valid) begin
                  cmd.rd_child_fast = 1'b1;
                  state_nxt         = S_CHILD;
                end else begin
                  cmd.rd_cur = 1'b1;
                  state_nxt  = S_CUR;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CUR: begin
        cmd.rd_child_slow = 1'b1;
        state_nxt         = S_CHILD;
      end
      S_CHILD: begin
        if (!status.leaf) begin
          cmd.step  = 1'b1;
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_cur_then_child: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CUR |=> state_r == S_CHILD)
    else $error("current-node fetch not followed by child fetch");

  a_leaf_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHILD && status.leaf && !status.out_free) |=> state_r == S_CHILD)
    else $error("leaf result dropped while output busy");

  a_ended_ignores_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_mode == M_BIT && status.ended)
      |=> state_r == S_IDLE)
    else $error("bit walked the tree after end of stream");

endmodule

// ===== rtl/core/htd_dpath.sv =====
// datapath of the huffman tree decoder: node store, walk registers, result register
module htd_dpath
  import htd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [IDX_W-1:0]     root_node,
  input  logic [SYM_IN_W-1:0]  end_symbol,
  input  logic [IDX_W-1:0]     in_node_index,
  input  logic                 in_node_is_leaf,
  input  logic [SYM_IN_W-1:0]  in_node_symbol,
  input  logic [IDX_W-1:0]     in_node_zero_child,
  input  logic [IDX_W-1:0]     in_node_one_child,
  input  logic                 in_code_bit,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [OUT_SYM_W-1:0] out_symbol,
  output logic                 out_end_mark
);

  logic [IDX_W-1:0]     current_r, current_nxt;
  logic                 ended_r, ended_nxt;
  logic                 cache_vld_r, cache_vld_nxt;
  node_t                cache_r, cache_nxt;
  logic                 bit_r, bit_nxt;
  logic [IDX_W-1:0]     child_r, child_nxt;
  logic                 rd_oob_r, rd_oob_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic                 out_end_r, out_end_nxt;

  logic [NODE_W-1:0] rdata;
  node_t             data_eff;
  node_t             wr_node;
  logic              wr_en;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic              out_free;
  logic              is_end;

  // out-of-range reads see an all-zero entry
  assign data_eff = rd_oob_r ? '0 : node_t'(rdata);

  assign wr_node = '{leaf: in_node_is_leaf,
                     sym:  SYMBOL_BITS'(in_node_symbol),
                     zero: in_node_zero_child,
                     one:  in_node_one_child};
  assign wr_en   = cmd.load && (32'(in_node_index) < NODE_COUNT);

  always_comb begin
    rd_idx = current_r;
    if (cmd.rd_child_fast) begin
      rd_idx = in_code_bit ? cache_r.one : cache_r.zero;
    end else if (cmd.rd_child_slow) begin
      rd_idx = bit_r ? data_eff.one : data_eff.zero;
    end
  end

  assign rd_en = cmd.rd_cur || cmd.rd_child_fast || cmd.rd_child_slow;

  htd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (NODE_AW'(in_node_index)),
    .wdata (wr_node),
    .re    (rd_en),
    .raddr (NODE_AW'(rd_idx)),
    .rdata (rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign is_end   = data_eff.sym == SYMBOL_BITS'(end_symbol);

  always_comb begin
    current_nxt   = current_r;
    ended_nxt     = ended_r;
    cache_vld_nxt = cache_vld_r;
    cache_nxt     = cache_r;
    bit_nxt       = bit_r;
    child_nxt     = child_r;
    rd_oob_nxt    = rd_oob_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sym_nxt   = out_sym_r;
    out_end_nxt   = out_end_r;

    if (rd_en) begin
      rd_oob_nxt = !(32'(rd_idx) < NODE_COUNT);
    end
    if (cmd.rd_cur) begin
      bit_nxt = in_code_bit;
    end
    if (cmd.rd_child_fast || cmd.rd_child_slow) begin
      child_nxt = rd_idx;
    end
    // entry of the current node arrives before its child is fetched
    if (cmd.rd_child_slow) begin
      cache_nxt     = data_eff;
      cache_vld_nxt = 1'b1;
    end
    if (cmd.load) begin
      cache_vld_nxt = 1'b0;
    end
    if (cmd.restart) begin
      current_nxt   = root_node;
      ended_nxt     = 1'b0;
      cache_vld_nxt = 1'b0;
    end
    if (cmd.step) begin
      current_nxt   = child_r;
      cache_nxt     = data_eff;
      cache_vld_nxt = 1'b1;
    end
    if (cmd.emit) begin
      current_nxt   = root_node;
      cache_vld_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      if (is_end) begin
        ended_nxt   = 1'b1;
        out_sym_nxt = '0;
        out_end_nxt = 1'b1;
      end else begin
        out_sym_nxt = OUT_SYM_W'(data_eff.sym);
        out_end_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_r   <= '0;
      ended_r     <= 1'b0;
      cache_vld_r <= 1'b0;
      rd_oob_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      current_r   <= current_nxt;
      ended_r     <= ended_nxt;
      cache_vld_r <= cache_vld_nxt;
      rd_oob_r    <= rd_oob_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cache_r   <= cache_nxt;
    bit_r     <= bit_nxt;
    child_r   <= child_nxt;
    out_sym_r <= out_sym_nxt;
    out_end_r <= out_end_nxt;
  end

  assign status = '{cache_valid: cache_vld_r,
                    ended:       ended_r,
                    leaf:        data_eff.leaf,
                    out_free:    out_free};

  assign out_valid    = out_valid_r;
  assign out_symbol   = out_sym_r;
  assign out_end_mark = out_end_r;

  a_emit_on_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> data_eff.leaf)
    else $error("result emitted from an internal node");

  a_end_mark_zero_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> out_sym_r == '0)
    else $error("end mark carries a nonzero symbol");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready)
      |=> (out_valid_r && $stable(out_sym_r) && $stable(out_end_r)))
    else $error("result changed while stalled");

endmodule
